>>> rtl/rtfp_pkg.sv
// ============================================================================
// rtfp_pkg
// Shared types, constants and decode helpers for the radar target frame parser.
// ============================================================================
package rtfp_pkg;

    // Default frame geometry.
    localparam int TARGETS_DEF      = 3;
    localparam int RECORD_BYTES_DEF = 8;

    // Fixed frame framing.
    localparam int HEADER_LEN  = 4;
    localparam int FOOTER_LEN  = 2;
    // Bytes of each record that carry x, y and speed.
    localparam int FIELD_BYTES = 6;

    localparam logic [7:0] SYNC_PATTERN [HEADER_LEN] = '{8'hAA, 8'hFF, 8'h03, 8'h00};
    localparam logic [7:0] FOOTER_LO  = 8'h55;
    localparam logic [7:0] FOOTER_HI  = 8'hCC;
    localparam logic [15:0] SIGN_MASK = 16'h8000;
    localparam logic [15:0] MAG_MASK  = 16'h7FFF;

    // Result kinds carried on tuser.
    localparam logic KIND_TARGET = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    // The six payload bytes of one target record, byte 0 first.
    typedef logic [7:0] record_t [FIELD_BYTES];

    // Decoded fields of one target.
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] speed_cm_s;
        logic               active;
    } target_t;

    // Little-endian sign-magnitude to two's complement. A set top bit means
    // positive; a clear top bit means negative, and negative zero becomes 0.
    function automatic logic signed [15:0] sm_to_tc(input logic [7:0] lo,
                                                    input logic [7:0] hi);
        logic [15:0] raw;
        logic [15:0] mag;
        raw = {hi, lo};
        mag = raw & MAG_MASK;
        if ((raw & SIGN_MASK) != 16'h0000)
        begin
            return mag;
        end
        return 16'h0000 - mag;
    endfunction

endpackage

>>> rtl/radar_target_frame_parser_top.sv
// ============================================================================
// radar_target_frame_parser_top
// Locks onto the AA FF 03 00 header, stores the target records of a frame in
// a byte memory, checks the 55 CC footer and reports one item per target, or
// one error item for a bad footer.
// ============================================================================
//
//  Channel   Dir  tdata                                   tuser  tlast
//  s_axis    in   data_byte[7:0]                          -      -
//  m_axis    out  target_index, pos_x, pos_y, speed,      kind   last
//                 active (56 bits, zero filled)
//
//  s_axis accepts a byte whenever the parser is idle; tready is low only
//  while a completed frame is unloaded. For a good frame the unload reads
//  each target record as six memory reads, each followed by a capture, then
//  loads the output; a bad footer skips the reads and loads the error item.
//  The single read port of the record memory serialises the reads. A stalled
//  m_axis holds the output register and the unload waits for it. rst_n clears
//  the byte count, state and output register; the record memory has no reset.
//
module radar_target_frame_parser_top #(
    parameter int TARGETS      = rtfp_pkg::TARGETS_DEF,
    parameter int RECORD_BYTES = rtfp_pkg::RECORD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata: [7:0] data_byte
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // m_axis_tdata: [1:0] target_index, [17:2] pos_x, [33:18] pos_y,
    // [49:34] speed_cm_s, [50] active, [55:51] zero
    output logic [55:0] m_axis_tdata,
    // m_axis_tuser: [0] kind
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);
    import rtfp_pkg::*;

    localparam int BODY_LEN  = TARGETS * RECORD_BYTES;
    localparam int FRAME_LEN = HEADER_LEN + BODY_LEN + FOOTER_LEN;
    localparam int CNT_W     = $clog2(FRAME_LEN);
    localparam int ADDR_W    = $clog2(BODY_LEN);
    localparam int TGT_W     = (TARGETS > 1) ? $clog2(TARGETS) : 1;
    localparam int K_W       = $clog2(FIELD_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CAPTURE,
        S_EMIT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              footer_lo_reg;
    logic              error_reg;
    logic [TGT_W-1:0]  tgt_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [K_W-1:0]    k_reg;
    record_t           rec_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        mem [BODY_LEN];

    logic              in_fire;
    logic              out_free;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              last_tgt;
    target_t           target;

    logic [1:0]         out_idx_reg;
    logic signed [15:0] out_x_reg;
    logic signed [15:0] out_y_reg;
    logic signed [15:0] out_s_reg;
    logic               out_active_reg;
    logic               out_kind_reg;
    logic               out_last_reg;
    logic               out_valid_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign last_tgt      = (tgt_reg == TGT_W'(TARGETS - 1));

    // Record bytes land at their offset past the header; footer bytes are not stored.
    assign mem_we  = in_fire && (count_reg >= CNT_W'(HEADER_LEN))
                     && (count_reg < CNT_W'(HEADER_LEN + BODY_LEN));
    assign wr_addr = ADDR_W'(count_reg - CNT_W'(HEADER_LEN));
    assign rd_addr = base_reg + ADDR_W'(k_reg);

    // Record memory, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= s_axis_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    rtfp_record_decode u_decode (
        .rec    (rec_reg),
        .target (target)
    );

    // Frame sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            footer_lo_reg  <= 1'b0;
            error_reg      <= 1'b0;
            tgt_reg        <= '0;
            base_reg       <= '0;
            k_reg          <= '0;
            rec_reg        <= '{default: 8'h00};
            out_idx_reg    <= 2'd0;
            out_x_reg      <= 16'sd0;
            out_y_reg      <= 16'sd0;
            out_s_reg      <= 16'sd0;
            out_active_reg <= 1'b0;
            out_kind_reg   <= KIND_TARGET;
            out_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (count_reg < CNT_W'(HEADER_LEN))
                        begin
                            // Header hunt: a stray AA restarts the match at one.
                            if (s_axis_tdata == SYNC_PATTERN[count_reg[1:0]])
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            else if (s_axis_tdata == SYNC_PATTERN[0])
                            begin
                                count_reg <= CNT_W'(1);
                            end
                            else
                            begin
                                count_reg <= '0;
                            end
                        end
                        else if (count_reg == CNT_W'(FRAME_LEN - 1))
                        begin
                            // Frame complete: check footer and start the unload.
                            count_reg <= '0;
                            tgt_reg   <= '0;
                            base_reg  <= '0;
                            k_reg     <= '0;
                            if (footer_lo_reg && (s_axis_tdata == FOOTER_HI))
                            begin
                                error_reg <= 1'b0;
                                state_reg <= S_READ;
                            end
                            else
                            begin
                                error_reg <= 1'b1;
                                state_reg <= S_EMIT;
                            end
                        end
                        else
                        begin
                            if (count_reg == CNT_W'(FRAME_LEN - 2))
                            begin
                                footer_lo_reg <= (s_axis_tdata == FOOTER_LO);
                            end
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CAPTURE;
                end
                S_CAPTURE:
                begin
                    rec_reg[k_reg] <= rd_data_reg;
                    if (k_reg == K_W'(FIELD_BYTES - 1))
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (error_reg)
                        begin
                            out_kind_reg   <= KIND_ERROR;
                            out_idx_reg    <= 2'd0;
                            out_x_reg      <= 16'sd0;
                            out_y_reg      <= 16'sd0;
                            out_s_reg      <= 16'sd0;
                            out_active_reg <= 1'b0;
                            out_last_reg   <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            out_kind_reg   <= KIND_TARGET;
                            out_idx_reg    <= 2'(tgt_reg);
                            out_x_reg      <= target.pos_x;
                            out_y_reg      <= target.pos_y;
                            out_s_reg      <= target.speed_cm_s;
                            out_active_reg <= target.active;
                            out_last_reg   <= last_tgt;
                            if (last_tgt)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                tgt_reg   <= tgt_reg + 1'b1;
                                base_reg  <= base_reg + ADDR_W'(RECORD_BYTES);
                                k_reg     <= '0;
                                state_reg <= S_READ;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output packing.
    assign m_axis_tdata  = {5'd0, out_active_reg, out_s_reg, out_y_reg, out_x_reg, out_idx_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tvalid = out_valid_reg;

`ifndef SYNTH
    // An error item is a lone, all-zero, final item.
    a_error_item: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_ERROR))
        |-> (m_axis_tlast && (m_axis_tdata == 56'd0)))
        else $error("error item with payload or without last");

    // The byte count restarts for every frame unload.
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (count_reg == '0))
        else $error("byte count not cleared during unload");

    // The byte count stays inside one frame.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(FRAME_LEN))
        else $error("byte count out of frame range");

    // A pending item is never overwritten by the unload.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && out_valid_reg && !m_axis_tready)
        |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast) && (state_reg == S_EMIT)))
        else $error("output register changed while stalled");

    // No record byte is written while a frame is being read back.
    a_no_write_unload: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE))
        else $error("record memory written during unload");
`endif

endmodule

>>> rtl/rtfp_record_decode.sv
// ============================================================================
// rtfp_record_decode
// Turns the six payload bytes of one target record into signed x, y and
// speed values plus the active flag.
// ============================================================================
module rtfp_record_decode (
    input  rtfp_pkg::record_t rec,
    output rtfp_pkg::target_t target
);
    import rtfp_pkg::*;

    logic signed [15:0] x_val;
    logic signed [15:0] y_val;

    // Each field is a little-endian sign-magnitude pair.
    assign x_val = sm_to_tc(rec[0], rec[1]);
    assign y_val = sm_to_tc(rec[2], rec[3]);

    // A target is active when either coordinate is nonzero.
    always_comb
    begin
        target.pos_x      = x_val;
        target.pos_y      = y_val;
        target.speed_cm_s = sm_to_tc(rec[4], rec[5]);
        target.active     = (x_val != 16'sd0) || (y_val != 16'sd0);
    end

endmodule
